// ===== hw/rtl/uer_pkg.sv =====
// uer_pkg: beat types, configuration record and fixed constants for the echo ranger
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package uer_pkg;

  // tick beat: one microsecond sample of the echo pin plus an optional start
  typedef struct packed {
    logic       command;
    logic [3:0] sensor_select;
    logic       echo_level;
  } tick_t;

  // result beat: one per tick
  typedef struct packed {
    logic       trigger_enable;
    logic       trigger_level;
    logic       busy_res;
    logic       done_res;
    logic [9:0] distance_cm;
    logic [3:0] sensor_out;
  } res_t;

  // configuration registers as seen by the datapath
  typedef struct packed {
    logic [15:0] timeout_limit;
    logic [15:0] divide_mask;
    logic [9:0]  saturate_limit;
    logic [9:0]  timeout_code;
  } cfg_t;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT_LIMIT  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DIVIDE_MASK    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SATURATE_LIMIT = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT_CODE   = 2'd3;

  // reset values
  localparam logic [15:0] RST_TIMEOUT_LIMIT  = 16'd50000;
  localparam logic [15:0] RST_DIVIDE_MASK    = 16'd0;
  localparam logic [9:0]  RST_SATURATE_LIMIT = 10'd200;
  localparam logic [9:0]  RST_TIMEOUT_CODE   = 10'd253;

  localparam int TIMER_W = 16;
  localparam int DIST_W  = 10;

  // trigger drive lengths in ticks
  localparam int LOW1_TICKS = 2;
  localparam int HIGH_TICKS = 7;
  localparam int LOW2_TICKS = 5;

  // width conversion: counts at or above this give a distance over 1023
  // on both paths, so the count is clamped here before the multiply
  localparam int COUNT_CLAMP = 60236;
  localparam int CONV_X_W    = 16;
  localparam int RECIP_W     = 21;
  localparam int CONV_SHIFT  = 26;
  localparam int CONV_Q_W    = 11;
  // ceil(2^26 / 58) and ceil(17 * 2^26 / 1000); exact for counts below the clamp
  localparam logic [RECIP_W-1:0] RECIP_DIV58 = 21'd1157050;
  localparam logic [RECIP_W-1:0] RECIP_CM    = 21'd1140851;

endpackage

`default_nettype wire

// ===== hw/rtl/ultrasonic_echo_ranger_top.sv =====
// ultrasonic_echo_ranger_top: input stage, sequencer and result register of the ranger
// depends on uer_pkg, uer_cfg_regs, uer_core (which uses uer_conv)
`timescale 1ns / 1ps
`default_nettype none

// usage
//   tick channel (tick_valid / tick_stall / tick_data): one beat per microsecond
//   tick, carrying the echo pin sample and an optional start command with a
//   sensor index. every tick beat yields exactly one result beat.
//   result channel (res_valid / res_stall / res_data): trigger pin drive, busy,
//   done and the last distance with its sensor index.
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data): register writes,
//   always ready; write only while no measurement is running.
// path and throughput
//   a tick beat lands in the input register; as it leaves, the sequencer
//   processes it and its result is loaded into the result register, from
//   which the result beat is taken. one beat per cycle is sustained while
//   results are not stalled; the per-tick sequencer update is the only loop.
// reset
//   synchronous rst empties both registers, puts the sequencer in idle with
//   zero count, sensor and distance, and loads register reset values.
// stall
//   a stalled result holds; the input register still takes one more beat,
//   after which tick_stall rises until the result is taken.
module ultrasonic_echo_ranger_top
  import uer_pkg::*;
#(
  parameter int SENSOR_COUNT = 16,
  parameter int COUNTER_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   tick_valid,
  output logic                   tick_stall,
  input  tick_t                  tick_data,
  output logic                   res_valid,
  input  logic                   res_stall,
  output res_t                   res_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t  cfg;
  logic  s1_valid;
  tick_t s1_data;
  logic  s1_adv;
  res_t  res_next;

  uer_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // input stage moves on when the result register is empty or being drained
  assign s1_adv     = s1_valid && (!res_valid || !res_stall);
  assign tick_stall = s1_valid && !s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!tick_stall) begin
      s1_valid <= tick_valid;
    end
  end

  // payload only, no reset needed
  always_ff @(posedge clk) begin
    if (tick_valid && !tick_stall) begin
      s1_data <= tick_data;
    end
  end

  // sequencer state advances exactly once per beat, as it leaves the input stage
  uer_core #(
    .SENSOR_COUNT (SENSOR_COUNT),
    .COUNTER_BITS (COUNTER_BITS)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .step (s1_adv),
    .tick (s1_data),
    .cfg  (cfg),
    .res  (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_adv) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res_data <= res_next;
    end
  end

  // a beat leaving the input stage is in the result register next cycle
  a_adv_lands: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> res_valid)
    else $error("processed beat did not reach the result register");

  // a distance is only produced inside a measurement
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.done_res |-> res_data.busy_res)
    else $error("done without busy");

  // the pin is driven high only while driven
  a_level_en: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.trigger_level |-> res_data.trigger_enable)
    else $error("trigger level high while pin released");

  // an idle tick neither drives the pin nor reports a distance
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_data.busy_res |-> !res_data.trigger_enable && !res_data.done_res)
    else $error("activity outside a measurement");

endmodule

`default_nettype wire

// ===== hw/rtl/uer_cfg_regs.sv =====
// uer_cfg_regs: configuration register file written through the cfg channel
// depends on uer_pkg
`timescale 1ns / 1ps
`default_nettype none

module uer_cfg_regs
  import uer_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                   cfg
);

  // writes must only happen while idle, which this block does not enforce; they are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout_limit  <= RST_TIMEOUT_LIMIT;
      cfg.divide_mask    <= RST_DIVIDE_MASK;
      cfg.saturate_limit <= RST_SATURATE_LIMIT;
      cfg.timeout_code   <= RST_TIMEOUT_CODE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TIMEOUT_LIMIT:  cfg.timeout_limit  <= cfg_data;
        REG_DIVIDE_MASK:    cfg.divide_mask    <= cfg_data;
        REG_SATURATE_LIMIT: cfg.saturate_limit <= cfg_data[DIST_W-1:0];
        REG_TIMEOUT_CODE:   cfg.timeout_code   <= cfg_data[DIST_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/uer_conv.sv =====
// uer_conv: echo width count to distance, one shared reciprocal multiplier
// depends on uer_pkg
`timescale 1ns / 1ps
`default_nettype none

module uer_conv
  import uer_pkg::*;
#(
  parameter int CNT_W = 16
) (
  input  logic [CNT_W-1:0]  count,
  input  logic              use_div,
  input  logic [DIST_W-1:0] sat_limit,
  output logic [DIST_W-1:0] distance
);

  logic [31:0]                    count_wide;
  logic [CONV_X_W-1:0]            x;
  logic [RECIP_W-1:0]             recip;
  logic [CONV_X_W+RECIP_W-1:0]    prod;
  logic [CONV_Q_W-1:0]            q;

  assign count_wide = 32'(count);
  // clamp keeps the multiplier narrow; any clamped count saturates anyway
  assign x     = (count_wide >= 32'(COUNT_CLAMP)) ? CONV_X_W'(COUNT_CLAMP)
                                                  : count_wide[CONV_X_W-1:0];
  assign recip = use_div ? RECIP_DIV58 : RECIP_CM;
  assign prod  = (CONV_X_W+RECIP_W)'(x) * (CONV_X_W+RECIP_W)'(recip);
  assign q     = prod[CONV_SHIFT +: CONV_Q_W];

  always_comb begin
    if (use_div) begin
      distance = q[CONV_Q_W-1] ? {DIST_W{1'b1}} : q[DIST_W-1:0];
    end else begin
      distance = (q > {1'b0, sat_limit}) ? sat_limit : q[DIST_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/uer_core.sv =====
// uer_core: measurement sequencer; trigger drive, echo phases and result build
// depends on uer_pkg and uer_conv
`timescale 1ns / 1ps
`default_nettype none

module uer_core
  import uer_pkg::*;
#(
  parameter int SENSOR_COUNT = 16,
  parameter int COUNTER_BITS = 16
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  step,
  input  tick_t tick,
  input  cfg_t  cfg,
  output res_t  res
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_LOW1, PH_HIGH, PH_LOW2, PH_WLOW, PH_WHIGH, PH_WIDTH
  } phase_t;

  localparam int LIM_W = (COUNTER_BITS > TIMER_W) ? COUNTER_BITS : TIMER_W;

  phase_t                  phase, phase_next, ph_eff;
  logic [COUNTER_BITS-1:0] tick_count, tick_count_next, cnt_eff, cnt_inc;
  logic [3:0]              active_sensor, sens_eff;
  logic [DIST_W-1:0]       last_distance, last_distance_next, conv_dist;
  logic                    start, gives_up;
  logic [COUNTER_BITS-1:0] drive_end;

  assign start = (phase == PH_IDLE) && tick.command &&
                 (7'(tick.sensor_select) < 7'(SENSOR_COUNT));

  assign ph_eff   = start ? PH_LOW1 : phase;
  assign cnt_eff  = start ? '0 : tick_count;
  assign sens_eff = start ? tick.sensor_select : active_sensor;
  assign cnt_inc  = cnt_eff + 1'b1;

  assign gives_up = (LIM_W'(cnt_eff) >= LIM_W'(cfg.timeout_limit)) || (&cnt_eff);

  uer_conv #(
    .CNT_W(COUNTER_BITS)
  ) u_conv (
    .count     (cnt_eff),
    .use_div   (cfg.divide_mask[sens_eff]),
    .sat_limit (cfg.saturate_limit),
    .distance  (conv_dist)
  );

  always_comb begin
    phase_next         = ph_eff;
    tick_count_next    = cnt_eff;
    last_distance_next = last_distance;
    drive_end          = COUNTER_BITS'(LOW1_TICKS - 1);
    res.trigger_enable = 1'b0;
    res.trigger_level  = 1'b0;
    res.busy_res       = (ph_eff != PH_IDLE);
    res.done_res       = 1'b0;
    case (ph_eff)
      PH_LOW1, PH_HIGH, PH_LOW2: begin
        res.trigger_enable = 1'b1;
        res.trigger_level  = (ph_eff == PH_HIGH);
        case (ph_eff)
          PH_HIGH: drive_end = COUNTER_BITS'(HIGH_TICKS - 1);
          PH_LOW2: drive_end = COUNTER_BITS'(LOW2_TICKS - 1);
          default: drive_end = COUNTER_BITS'(LOW1_TICKS - 1);
        endcase
        if (cnt_eff >= drive_end) begin
          phase_next      = phase_t'(ph_eff + 3'd1);
          tick_count_next = '0;
        end else begin
          tick_count_next = cnt_inc;
        end
      end
      PH_WLOW, PH_WHIGH: begin
        // wait for the awaited echo level; a timeout just moves on
        if ((tick.echo_level == (ph_eff == PH_WHIGH)) || gives_up) begin
          phase_next      = phase_t'(ph_eff + 3'd1);
          tick_count_next = '0;
        end else begin
          tick_count_next = cnt_inc;
        end
      end
      PH_WIDTH: begin
        if (!tick.echo_level) begin
          last_distance_next = conv_dist;
          res.done_res       = 1'b1;
          phase_next         = PH_IDLE;
          tick_count_next    = '0;
        end else if (gives_up) begin
          last_distance_next = cfg.timeout_code;
          res.done_res       = 1'b1;
          phase_next         = PH_IDLE;
          tick_count_next    = '0;
        end else begin
          tick_count_next = cnt_inc;
        end
      end
      default: begin
        phase_next      = PH_IDLE;
        tick_count_next = '0;
      end
    endcase
    res.distance_cm = last_distance_next;
    res.sensor_out  = sens_eff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      tick_count    <= '0;
      active_sensor <= '0;
      last_distance <= '0;
    end else if (step) begin
      phase         <= phase_next;
      tick_count    <= tick_count_next;
      active_sensor <= sens_eff;
      last_distance <= last_distance_next;
    end
  end

endmodule

`default_nettype wire

// ===== dv/ultrasonic_echo_ranger_top_tb.sv =====
// ultrasonic_echo_ranger_top_tb: self-checking echo ranger bench, one tick beat per cycle while steady
// depends on uer_pkg and ultrasonic_echo_ranger_top; a built-in predictor checks every result beat
`timescale 1ns / 1ps

module ultrasonic_echo_ranger_top_tb;
  import uer_pkg::*;

  localparam int SENSOR_COUNT = 16;
  localparam int COUNTER_BITS = 16;
  localparam int unsigned COUNT_MAX = (32'd1 << COUNTER_BITS) - 1;

  // cm conversion: width / 58, or width * 17 / 1000 clipped at saturate_limit
  localparam int unsigned CM_DIVISOR = 58;
  localparam int unsigned CM_NUM     = 17;
  localparam int unsigned CM_DEN     = 1000;
  localparam int unsigned DIST_CAP   = 1023;

  localparam int RST_CYCLES   = 7;
  localparam int DRAIN_CYCLES = 8;     // a result beat follows its tick through the input and result registers
  localparam int STALL_LIMIT  = 1000;  // watchdog limit, above the longest gap idle_len gives on either side
  localparam int RAND_PHASES  = 4;
  localparam int PHASE_TICKS  = 120;
  localparam int MAX_REPORTS  = 30;

  // measurement sequencer phases of the predictor
  typedef enum logic [2:0] {
    RG_IDLE, RG_LOW1, RG_HIGH, RG_LOW2, RG_WAIT_LOW, RG_WAIT_HIGH, RG_WIDTH
  } rg_phase_t;

  logic                   clk;
  logic                   rst        = 1'b1;
  logic                   tick_valid = 1'b0;
  logic                   tick_stall;
  tick_t                  tick_data  = '0;
  logic                   res_valid;
  logic                   res_stall  = 1'b0;
  res_t                   res_data;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;

  ultrasonic_echo_ranger_top #(
    .SENSOR_COUNT(SENSOR_COUNT),
    .COUNTER_BITS(COUNTER_BITS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .tick_valid(tick_valid),
    .tick_stall(tick_stall),
    .tick_data (tick_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ranger state as the predictor sees it
  cfg_t        rg_cfg = '{RST_TIMEOUT_LIMIT, RST_DIVIDE_MASK, RST_SATURATE_LIMIT, RST_TIMEOUT_CODE};
  rg_phase_t   rg_phase  = RG_IDLE;
  int unsigned rg_count  = 0;
  logic [3:0]  rg_sensor = '0;
  logic [9:0]  rg_dist   = '0;

  tick_t pending_ticks[$];   // beats waiting for the driver
  res_t  expected_res[$];    // predicted result beats, oldest first

  int unsigned n_queued   = 0;
  int unsigned n_taken    = 0;
  int unsigned n_checked  = 0;
  int unsigned n_err      = 0;
  int unsigned n_done     = 0;
  int unsigned n_width_to = 0;
  int unsigned n_cfg      = 0;
  int unsigned src_wait   = 0;
  int unsigned snk_wait   = 0;
  int unsigned idle_cycles = 0;
  bit          steady     = 1'b0;   // no idling on either side while set
  res_t        want_res;

  // an echo wait phase gives up at the limit or when the counter is full
  function automatic bit echo_gives_up(input int unsigned s);
    return (s >= rg_cfg.timeout_limit) || (s >= COUNT_MAX);
  endfunction

  // advance the ranger by one tick and return the result beat it gives
  function automatic res_t range_tick(input tick_t t);
    res_t        r;
    int unsigned s;
    int unsigned len;
    int unsigned d;
    r = '0;
    // start only from idle; a start while busy is dropped
    if (rg_phase == RG_IDLE && t.command && t.sensor_select < SENSOR_COUNT) begin
      rg_sensor = t.sensor_select;
      rg_phase  = RG_LOW1;
      rg_count  = 0;
    end
    r.busy_res = (rg_phase != RG_IDLE);
    s = rg_count;
    case (rg_phase)
      // trigger drive: echo is not looked at
      RG_LOW1, RG_HIGH, RG_LOW2: begin
        len = (rg_phase == RG_LOW1) ? LOW1_TICKS :
              (rg_phase == RG_HIGH) ? HIGH_TICKS : LOW2_TICKS;
        r.trigger_enable = 1'b1;
        r.trigger_level  = (rg_phase == RG_HIGH);
        s = s + 1;
        if (s >= len) begin
          rg_phase = rg_phase_t'(rg_phase + 3'd1);
          s = 0;
        end
        rg_count = s;
      end
      // awaited edge or timeout both move on to the next phase
      RG_WAIT_LOW, RG_WAIT_HIGH: begin
        if (t.echo_level == (rg_phase == RG_WAIT_HIGH) || echo_gives_up(s)) begin
          rg_phase = rg_phase_t'(rg_phase + 3'd1);
          rg_count = 0;
        end else begin
          rg_count = s + 1;
        end
      end
      RG_WIDTH: begin
        if (!t.echo_level) begin
          if (rg_cfg.divide_mask[rg_sensor]) begin
            d = s / CM_DIVISOR;
            if (d > DIST_CAP) d = DIST_CAP;
          end else begin
            d = (s * CM_NUM) / CM_DEN;
            if (d > rg_cfg.saturate_limit) d = rg_cfg.saturate_limit;
          end
          rg_dist    = 10'(d);
          r.done_res = 1'b1;
          rg_phase   = RG_IDLE;
          rg_count   = 0;
          n_done++;
        end else if (echo_gives_up(s)) begin
          rg_dist    = rg_cfg.timeout_code;
          r.done_res = 1'b1;
          rg_phase   = RG_IDLE;
          rg_count   = 0;
          n_done++;
          n_width_to++;
        end else begin
          rg_count = s + 1;
        end
      end
      default: begin
        rg_phase = RG_IDLE;
        rg_count = 0;
      end
    endcase
    r.distance_cm = rg_dist;
    r.sensor_out  = rg_sensor;
    return r;
  endfunction

  // gap length: mostly none or short, now and then long
  function automatic int unsigned idle_len();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // length of one echo level inside a measurement
  function automatic int unsigned echo_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 8);
    if (r < 95) return $urandom_range(9, 40);
    return $urandom_range(41, 200);
  endfunction

  task automatic push_tick(input logic cmd, input logic [3:0] sel, input logic echo);
    tick_t t;
    t.command       = cmd;
    t.sensor_select = sel;
    t.echo_level    = echo;
    pending_ticks.push_back(t);
    n_queued++;
  endtask

  // n plain ticks at a fixed echo level, sensor field random
  task automatic push_run(input int unsigned n, input logic echo);
    repeat (n) push_tick(1'b0, 4'($urandom), echo);
  endtask

  // one well-formed measurement: start, drive ticks with stray starts and echo noise,
  // echo high then low, low then high, then a high pulse of the given width
  task automatic queue_measurement(input logic [3:0] sel, input int unsigned hold_hi,
                                   input int unsigned hold_lo, input int unsigned width);
    push_tick(1'b1, sel, 1'($urandom));
    repeat (LOW1_TICKS + HIGH_TICKS + LOW2_TICKS - 1)
      push_tick($urandom_range(0, 3) == 0, 4'($urandom), 1'($urandom));
    push_run(hold_hi, 1'b1);
    push_tick(1'b0, 4'($urandom), 1'b0);
    push_run(hold_lo, 1'b0);
    push_tick(1'b0, 4'($urandom), 1'b1);
    push_run(width, 1'b1);
    push_tick(1'b0, 4'($urandom), 1'b0);
  endtask

  // one register beat; valid stays up so back-to-back writes need not lower and raise it again
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_TIMEOUT_LIMIT:  rg_cfg.timeout_limit  = val;
      REG_DIVIDE_MASK:    rg_cfg.divide_mask    = val;
      REG_SATURATE_LIMIT: rg_cfg.saturate_limit = val[DIST_W-1:0];
      REG_TIMEOUT_CODE:   rg_cfg.timeout_code   = val[DIST_W-1:0];
      default: ;
    endcase
    n_cfg++;
  endtask

  task automatic load_config(input logic [15:0] lim, input logic [15:0] mask,
                             input logic [15:0] sat, input logic [15:0] code);
    write_reg(REG_TIMEOUT_LIMIT, lim);
    write_reg(REG_DIVIDE_MASK, mask);
    write_reg(REG_SATURATE_LIMIT, sat);
    write_reg(REG_TIMEOUT_CODE, code);
    cfg_valid <= 1'b0;
  endtask

  // bring the ranger back to idle, then hold off until every result beat is in
  task automatic settle();
    wait (n_taken == n_queued);
    while (rg_phase != RG_IDLE) begin
      // echo high closes the wait-high phase, echo low closes wait-low and width; drive phases just count on
      push_tick(1'b0, 4'd0, rg_phase == RG_WAIT_HIGH);
      wait (n_taken == n_queued);
    end
    wait (n_checked == n_taken);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cmp_field(input string fld, input int unsigned exp_v, input int unsigned act_v);
    if (exp_v != act_v) begin
      n_err++;
      if (n_err <= MAX_REPORTS)
        $display("%0t mismatch on %s: expected %0d, actual %0d", $time, fld, exp_v, act_v);
    end
  endtask

  // tick driver: the predictor runs on every accepted beat
  always @(posedge clk) begin
    if (rst) begin
      tick_valid <= 1'b0;
      src_wait   <= 0;
    end else begin
      if (tick_valid && !tick_stall) begin
        expected_res.push_back(range_tick(tick_data));
        n_taken++;
      end
      // payload only moves once the current beat is gone
      if (!tick_valid || !tick_stall) begin
        if (src_wait != 0) begin
          tick_valid <= 1'b0;
          src_wait   <= src_wait - 1;
        end else if (pending_ticks.size() != 0) begin
          tick_data  <= pending_ticks.pop_front();
          tick_valid <= 1'b1;
          src_wait   <= idle_len();
        end else begin
          tick_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random back-pressure
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
      snk_wait  <= 0;
    end else begin
      if (res_valid && !res_stall) begin
        if (expected_res.size() == 0) begin
          n_err++;
          if (n_err <= MAX_REPORTS)
            $display("%0t unexpected result beat: expected none, actual %h", $time, res_data);
        end else begin
          want_res = expected_res.pop_front();
          cmp_field("trigger_enable", want_res.trigger_enable, res_data.trigger_enable);
          cmp_field("trigger_level", want_res.trigger_level, res_data.trigger_level);
          cmp_field("busy_res", want_res.busy_res, res_data.busy_res);
          cmp_field("done_res", want_res.done_res, res_data.done_res);
          cmp_field("distance_cm", want_res.distance_cm, res_data.distance_cm);
          cmp_field("sensor_out", want_res.sensor_out, res_data.sensor_out);
          n_checked++;
        end
      end
      if (snk_wait != 0) begin
        res_stall <= 1'b1;
        snk_wait  <= snk_wait - 1;
      end else begin
        res_stall <= 1'b0;
        snk_wait  <= idle_len();
      end
    end
  end

  // watchdog: too long without any beat on any channel
  always @(posedge clk) begin
    if ((tick_valid && !tick_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t watchdog: no beat for %0d cycles", $time, STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned first;
    logic [15:0] lim;
    logic [15:0] sat;
    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // reset settings: zero width, sub-cm width, a few cm
    queue_measurement(4'd0, 0, 0, 0);
    queue_measurement(4'd15, 3, 2, 57);
    queue_measurement(4'd9, 0, 0, 120);
    settle();

    // zero timeout: each wait phase gives up on its first tick unless the edge is there
    load_config(16'd0, 16'hFFFF, 16'd0, 16'd0);
    queue_measurement(4'd1, 5, 5, 5);
    queue_measurement(4'd2, 0, 0, 0);
    settle();

    // divide path ignores the saturation limit, 17/1000 path reaches it without going over
    steady = 1'b1;
    load_config(16'hFFFF, 16'h0008, 16'd1, 16'd1023);
    queue_measurement(4'd3, 0, 0, 150);
    queue_measurement(4'd4, 0, 0, 100);
    settle();
    steady = 1'b0;

    // short timeout that each echo wait phase runs into
    load_config(16'd20, 16'h0000, 16'd5, 16'h02AA);
    queue_measurement(4'd6, 30, 30, 30);
    queue_measurement(4'd8, 4, 25, 10);
    settle();

    // random phases: mostly well-formed measurements, some noise and cut-off starts
    for (int p = 0; p < RAND_PHASES; p++) begin
      case ($urandom_range(0, 4))
        0:       lim = 16'd1;
        1:       lim = 16'($urandom_range(2, 12));
        2:       lim = 16'($urandom_range(13, 80));
        3:       lim = 16'hFFFF;
        default: lim = 16'($urandom);
      endcase
      sat = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 4)) : 16'($urandom);
      load_config(lim, 16'($urandom), sat, 16'($urandom));
      steady = ($urandom_range(0, 3) == 0);
      first = n_queued;
      while (n_queued - first < PHASE_TICKS) begin
        repeat ($urandom_range(0, 4))
          push_tick($urandom_range(0, 7) == 0, 4'($urandom), 1'($urandom));
        if ($urandom_range(0, 9) != 0)
          queue_measurement(4'($urandom), echo_len(), echo_len(), echo_len());
        else
          repeat ($urandom_range(3, 30)) push_tick(1'($urandom), 4'($urandom), 1'($urandom));
      end
      settle();
      steady = 1'b0;
    end

    $display("covered %0d ticks and %0d result beats: %0d distances, %0d width timeouts",
             n_taken, n_checked, n_done, n_width_to);
    $display("%0d register writes over %0d settings", n_cfg, n_cfg / 4);
    if (n_err == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
